>>> rtl/mdio_c22_pkg.sv
`timescale 1ns / 1ps

package mdio_c22_pkg;

  // Input word: a command or one MDC tick
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  phy_address;
    logic [7:0]  register_address;
    logic [15:0] write_value;
    logic [15:0] bit_mask;
    logic        line_sample;
  } cmd_t;

  // Result word
  typedef struct packed {
    logic        drive_bit;
    logic        drive_enable;
    logic        clock_pulse;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_value;
    logic [1:0]  status;
  } res_t;

  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_MODIFY = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd1;
  localparam logic [1:0] STATUS_BUSY     = 2'd2;

  localparam logic [1:0] OPC_READ  = 2'b10;
  localparam logic [1:0] OPC_WRITE = 2'b01;
  localparam logic [1:0] START_BITS = 2'b01;

  localparam int          CNT_W    = 6;
  localparam logic [5:0]  HDR_BITS  = 6'd14;
  localparam logic [5:0]  TA_BITS   = 6'd2;
  localparam logic [5:0]  DATA_BITS = 6'd16;
  localparam logic [7:0]  ADDR_MAX  = 8'd31;

endpackage

>>> rtl/mdio_c22_in_stage.sv
`timescale 1ns / 1ps

module mdio_c22_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mdio_c22_pkg::cmd_t  in_cmd,
  input  logic                advance,
  output logic                held_valid,
  output mdio_c22_pkg::cmd_t  held_cmd
);
  import mdio_c22_pkg::*;

  logic load;

  // Take a new word when the slot is empty or drains this cycle
  assign load     = !held_valid || advance;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      held_cmd <= in_cmd;
    end
  end

endmodule

>>> rtl/mdio_c22_core.sv
`timescale 1ns / 1ps

module mdio_c22_core #(
  parameter int MAX_PREAMBLE = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  mdio_c22_pkg::cmd_t  cmd,
  input  logic [5:0]          preamble_length,
  output mdio_c22_pkg::res_t  res
);
  import mdio_c22_pkg::*;

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_PRE  = 4'd1;
  localparam logic [3:0] PH_HDR  = 4'd2;
  localparam logic [3:0] PH_TA   = 4'd3;
  localparam logic [3:0] PH_DATA = 4'd4;

  localparam logic [CNT_W-1:0] PreMax = CNT_W'(MAX_PREAMBLE);

  logic [3:0]       phase, phase_next;
  logic [CNT_W-1:0] bit_counter, bit_counter_next;
  logic [1:0]       operation, operation_next;
  logic [13:0]      header_shift, header_shift_next;
  logic [15:0]      data_shift, data_shift_next;
  logic [15:0]      saved_value, saved_value_next;
  logic [15:0]      saved_mask, saved_mask_next;
  logic             modify_write_pending, modify_write_pending_next;

  logic [CNT_W-1:0] pre_sat;
  logic [3:0]       start_phase;
  logic [CNT_W-1:0] start_count;
  logic [CNT_W-1:0] count_dec;
  logic             frame_writes;
  logic [15:0]      shifted;
  logic [1:0]       opc;

  // Frame start: clamp the preamble, skip it entirely when zero
  assign pre_sat     = (preamble_length > PreMax) ? PreMax : preamble_length;
  assign start_phase = (pre_sat == '0) ? PH_HDR : PH_PRE;
  assign start_count = (pre_sat == '0) ? HDR_BITS : pre_sat;

  assign count_dec    = bit_counter - 1'b1;
  assign frame_writes = (operation == MODE_WRITE) || modify_write_pending;
  assign shifted      = frame_writes ? {data_shift[14:0], 1'b0}
                                     : {data_shift[14:0], cmd.line_sample};
  assign opc          = (cmd.mode == MODE_WRITE) ? OPC_WRITE : OPC_READ;

  always_comb begin
    phase_next                = phase;
    bit_counter_next          = bit_counter;
    operation_next            = operation;
    header_shift_next         = header_shift;
    data_shift_next           = data_shift;
    saved_value_next          = saved_value;
    saved_mask_next           = saved_mask;
    modify_write_pending_next = modify_write_pending;
    res                       = '0;

    if (cmd.mode != MODE_TICK) begin
      if (phase != PH_IDLE) begin
        res.status = STATUS_BUSY;
      end else if (cmd.phy_address > ADDR_MAX || cmd.register_address > ADDR_MAX) begin
        res.status   = STATUS_BAD_ADDR;
        res.done_res = 1'b1;
      end else begin
        operation_next            = cmd.mode;
        modify_write_pending_next = 1'b0;
        header_shift_next         = {START_BITS, opc, cmd.phy_address[4:0],
                                     cmd.register_address[4:0]};
        saved_value_next          = cmd.write_value;
        saved_mask_next           = cmd.bit_mask;
        data_shift_next           = (cmd.mode == MODE_WRITE) ? cmd.write_value : 16'd0;
        phase_next                = start_phase;
        bit_counter_next          = start_count;
      end
    end else if (phase != PH_IDLE) begin
      res.clock_pulse  = 1'b1;
      bit_counter_next = count_dec;
      unique case (phase)
        PH_PRE: begin
          res.drive_bit    = 1'b1;
          res.drive_enable = 1'b1;
          if (count_dec == '0) begin
            phase_next       = PH_HDR;
            bit_counter_next = HDR_BITS;
          end
        end
        PH_HDR: begin
          // Rotate so the header survives for the write frame of a modify
          res.drive_bit     = header_shift[13];
          res.drive_enable  = 1'b1;
          header_shift_next = {header_shift[12:0], header_shift[13]};
          if (count_dec == '0) begin
            phase_next       = PH_TA;
            bit_counter_next = TA_BITS;
          end
        end
        PH_TA: begin
          if (frame_writes) begin
            res.drive_enable = 1'b1;
            res.drive_bit    = (bit_counter == TA_BITS);
          end
          if (count_dec == '0) begin
            phase_next       = PH_DATA;
            bit_counter_next = DATA_BITS;
          end
        end
        default: begin
          if (frame_writes) begin
            res.drive_enable = 1'b1;
            res.drive_bit    = data_shift[15];
          end
          data_shift_next = shifted;
          if (count_dec == '0) begin
            if (operation == MODE_MODIFY && !modify_write_pending) begin
              // Merge and turn the read frame into a write frame
              data_shift_next           = (shifted & ~saved_mask) |
                                          (saved_value & saved_mask);
              saved_value_next          = shifted;
              modify_write_pending_next = 1'b1;
              header_shift_next         = {header_shift[13:12], OPC_WRITE,
                                           header_shift[9:0]};
              phase_next                = start_phase;
              bit_counter_next          = start_count;
            end else begin
              res.done_res = 1'b1;
              if (operation == MODE_READ) begin
                res.read_value = shifted;
              end else if (operation == MODE_MODIFY) begin
                res.read_value = saved_value;
              end
              phase_next                = PH_IDLE;
              bit_counter_next          = '0;
              modify_write_pending_next = 1'b0;
            end
          end
        end
      endcase
    end

    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_IDLE;
      bit_counter          <= '0;
      operation            <= '0;
      header_shift         <= '0;
      data_shift           <= '0;
      saved_value          <= '0;
      saved_mask           <= '0;
      modify_write_pending <= 1'b0;
    end else if (advance) begin
      phase                <= phase_next;
      bit_counter          <= bit_counter_next;
      operation            <= operation_next;
      header_shift         <= header_shift_next;
      data_shift           <= data_shift_next;
      saved_value          <= saved_value_next;
      saved_mask           <= saved_mask_next;
      modify_write_pending <= modify_write_pending_next;
    end
  end

endmodule

>>> rtl/mdio_clause22_master.sv
`timescale 1ns / 1ps

// Clause 22 MDIO management master. A command word (mode read, write or
// read-modify-write) loads a frame; each tick word (mode 3) then stands for
// one MDC cycle and returns the MDIO drive level and drive enable for it:
// preamble ones, start 01, opcode, PHY and register address, turnaround and
// 16 data bits, MSB first. For reads the line is released from turnaround
// on and line_sample is shifted in on each data tick. A modify runs a read
// frame, merges (read & ~mask) | (value & mask) and runs a write frame; the
// read value comes back with done_res. An address above 31 ends the command
// at once with status 1; a command while busy is dropped with status 2.
// Every input word yields exactly one result word. Throughput is one word
// per clock while out_stall is low; each word passes through the input register
// and then the result register, with the frame state updated as a word moves
// between them. preamble_length is sampled when each frame starts and is
// clamped to MAX_PREAMBLE.
module mdio_clause22_master #(
  parameter int MAX_PREAMBLE = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write_enable,
  input  logic [5:0]  cfg_write_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  phy_address,
  input  logic [7:0]  register_address,
  input  logic [15:0] write_value,
  input  logic [15:0] bit_mask,
  input  logic        line_sample,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        drive_bit,
  output logic        drive_enable,
  output logic        clock_pulse,
  output logic        busy_res,
  output logic        done_res,
  output logic [15:0] read_value,
  output logic [1:0]  status
);
  import mdio_c22_pkg::*;

  logic [5:0] preamble_length;
  cmd_t       in_cmd;
  cmd_t       held_cmd;
  logic       held_valid;
  logic       advance;
  res_t       res_comb;
  res_t       res_reg;

  // Preamble length register, reset to a full 32-bit preamble
  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_length <= 6'd32;
    end else if (cfg_write_enable) begin
      preamble_length <= cfg_write_data;
    end
  end

  assign in_cmd = '{mode:             mode,
                    phy_address:      phy_address,
                    register_address: register_address,
                    write_value:      write_value,
                    bit_mask:         bit_mask,
                    line_sample:      line_sample};

  // Advance the held word when the result register is empty or draining
  assign advance = held_valid && (!out_valid || !out_stall);

  mdio_c22_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .advance    (advance),
    .held_valid (held_valid),
    .held_cmd   (held_cmd)
  );

  mdio_c22_core #(
    .MAX_PREAMBLE (MAX_PREAMBLE)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .cmd             (held_cmd),
    .preamble_length (preamble_length),
    .res             (res_comb)
  );

  // Result register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res_comb;
    end
  end

  assign drive_bit    = res_reg.drive_bit;
  assign drive_enable = res_reg.drive_enable;
  assign clock_pulse  = res_reg.clock_pulse;
  assign busy_res     = res_reg.busy_res;
  assign done_res     = res_reg.done_res;
  assign read_value   = res_reg.read_value;
  assign status       = res_reg.status;

endmodule

>>> bench/mdio_clause22_master_test.sv
`timescale 1ns / 1ps

module mdio_clause22_master_test;
  import mdio_c22_pkg::*;

  localparam int PREAMBLE_CAP   = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_WORDS    = 120;

  typedef enum logic [2:0] {
    FRAME_IDLE,
    FRAME_PREAMBLE,
    FRAME_HEADER,
    FRAME_TURN,
    FRAME_DATA
  } frame_phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       cfg_write_enable = 1'b0;
  logic [5:0] cfg_write_data = '0;

  logic in_valid = 1'b0;
  logic in_stall;
  cmd_t in_word = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  res_t seen_word;

  // Hold every random gap off while set; used for one whole phase.
  logic steady = 1'b0;

  cmd_t cmd_backlog[$];
  res_t line_results_due[$];
  int   mismatch_count = 0;
  int   stalled_cycles = 0;

  // Shadow of the frame engine, advanced once per accepted word.
  logic [5:0]   preamble_setting = 6'd32;
  frame_phase_e frame_phase = FRAME_IDLE;
  logic [5:0]   bits_left = '0;
  logic [1:0]   frame_op = '0;
  logic [13:0]  header_bits = '0;
  logic [15:0]  data_bits = '0;
  logic [15:0]  held_value = '0;
  logic [15:0]  held_mask = '0;
  logic         write_pass = 1'b0;

  mdio_clause22_master #(
    .MAX_PREAMBLE(PREAMBLE_CAP)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (in_word.mode),
    .phy_address      (in_word.phy_address),
    .register_address (in_word.register_address),
    .write_value      (in_word.write_value),
    .bit_mask         (in_word.bit_mask),
    .line_sample      (in_word.line_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .drive_bit        (seen_word.drive_bit),
    .drive_enable     (seen_word.drive_enable),
    .clock_pulse      (seen_word.clock_pulse),
    .busy_res         (seen_word.busy_res),
    .done_res         (seen_word.done_res),
    .read_value       (seen_word.read_value),
    .status           (seen_word.status)
  );

  always #5 clk = ~clk;

  // Load the preamble counter from the current setting, clamped; a zero
  // length skips straight to the start bits.
  function automatic void start_frame();
    logic [5:0] len;
    len = (preamble_setting > PREAMBLE_CAP) ? 6'(PREAMBLE_CAP) : preamble_setting;
    if (len == 0) begin
      frame_phase = FRAME_HEADER;
      bits_left = HDR_BITS;
    end else begin
      frame_phase = FRAME_PREAMBLE;
      bits_left = len;
    end
  endfunction

  // Advance the shadow engine by one word and return the line state it
  // should report.
  function automatic res_t mdio_frame_step(cmd_t w);
    res_t r;
    logic writes;
    logic [15:0] rd;
    r = '0;
    writes = (frame_op == MODE_WRITE) || write_pass;
    if (w.mode != MODE_TICK) begin
      if (frame_phase != FRAME_IDLE) begin
        r.status = STATUS_BUSY;
      end else if (w.phy_address > ADDR_MAX || w.register_address > ADDR_MAX) begin
        r.status = STATUS_BAD_ADDR;
        r.done_res = 1'b1;
      end else begin
        frame_op = w.mode;
        write_pass = 1'b0;
        header_bits = {START_BITS, (w.mode == MODE_WRITE) ? OPC_WRITE : OPC_READ,
                       w.phy_address[4:0], w.register_address[4:0]};
        held_value = w.write_value;
        held_mask = w.bit_mask;
        data_bits = (w.mode == MODE_WRITE) ? w.write_value : '0;
        start_frame();
      end
    end else if (frame_phase != FRAME_IDLE) begin
      r.clock_pulse = 1'b1;
      bits_left = bits_left - 1'b1;
      case (frame_phase)
        FRAME_PREAMBLE: begin
          r.drive_bit = 1'b1;
          r.drive_enable = 1'b1;
          if (bits_left == 0) begin
            frame_phase = FRAME_HEADER;
            bits_left = HDR_BITS;
          end
        end
        FRAME_HEADER: begin
          // Rotate so the header survives for the write pass of a modify.
          r.drive_bit = header_bits[13];
          r.drive_enable = 1'b1;
          header_bits = {header_bits[12:0], header_bits[13]};
          if (bits_left == 0) begin
            frame_phase = FRAME_TURN;
            bits_left = TA_BITS;
          end
        end
        FRAME_TURN: begin
          if (writes) begin
            r.drive_enable = 1'b1;
            r.drive_bit = (bits_left == TA_BITS - 1'b1);
          end
          if (bits_left == 0) begin
            frame_phase = FRAME_DATA;
            bits_left = DATA_BITS;
          end
        end
        default: begin
          if (writes) begin
            r.drive_enable = 1'b1;
            r.drive_bit = data_bits[15];
            data_bits = data_bits << 1;
          end else begin
            data_bits = {data_bits[14:0], w.line_sample};
          end
          if (bits_left == 0) begin
            if (frame_op == MODE_MODIFY && !write_pass) begin
              // Merge and turn the read frame into the write frame.
              rd = data_bits;
              data_bits = (rd & ~held_mask) | (held_value & held_mask);
              held_value = rd;
              write_pass = 1'b1;
              header_bits[11:10] = OPC_WRITE;
              start_frame();
            end else begin
              r.done_res = 1'b1;
              if (frame_op == MODE_READ)
                r.read_value = data_bits;
              else if (frame_op == MODE_MODIFY)
                r.read_value = held_value;
              frame_phase = FRAME_IDLE;
              bits_left = '0;
              write_pass = 1'b0;
            end
          end
        end
      endcase
    end
    r.busy_res = (frame_phase != FRAME_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Ticks one frame takes at a given setting: preamble plus 32 frame bits.
  function automatic int frame_span(logic [5:0] pre);
    return ((pre > PREAMBLE_CAP) ? PREAMBLE_CAP : int'(pre))
           + int'(HDR_BITS) + int'(TA_BITS) + int'(DATA_BITS);
  endfunction

  function automatic cmd_t command_word(logic [1:0] m, logic [7:0] phy, logic [7:0] reg_addr,
                                        logic [15:0] value, logic [15:0] mask);
    cmd_t w;
    w.mode = m;
    w.phy_address = phy;
    w.register_address = reg_addr;
    w.write_value = value;
    w.bit_mask = mask;
    w.line_sample = 1'($urandom_range(1));
    return w;
  endfunction

  // Random command of any kind and any addresses; ignored when busy.
  function automatic cmd_t stray_command();
    return command_word(2'($urandom_range(2)), 8'($urandom), 8'($urandom),
                        16'($urandom), 16'($urandom));
  endfunction

  // Tick with garbage in the unused fields and a random line level.
  function automatic cmd_t tick_word();
    cmd_t w;
    w = cmd_t'({$urandom, $urandom});
    w.mode = MODE_TICK;
    return w;
  endfunction

  // Queue one command and exactly the ticks that finish it; optionally
  // drop a stray command into the middle of the frame.
  task automatic queue_transaction(input logic [1:0] m, input logic [7:0] phy,
                                   input logic [7:0] reg_addr, input logic [15:0] value,
                                   input logic [15:0] mask, input logic poke_busy,
                                   output int words);
    int n;
    int at;
    n = frame_span(preamble_setting) * ((m == MODE_MODIFY) ? 2 : 1);
    at = poke_busy ? $urandom_range(n - 1) : n;
    words = n + 1 + (poke_busy ? 1 : 0);
    cmd_backlog.push_back(command_word(m, phy, reg_addr, value, mask));
    for (int i = 0; i < n; i++) begin
      if (i == at)
        cmd_backlog.push_back(stray_command());
      cmd_backlog.push_back(tick_word());
    end
  endtask

  // Mostly whole transactions; the rest out-of-range commands between
  // frames and ticks while idle (those are not counted).
  task automatic random_phase(input int target);
    int made;
    int k;
    int roll;
    cmd_t w;
    made = 0;
    while (made < target) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        queue_transaction(2'($urandom_range(2)), 8'($urandom_range(31)),
                          8'($urandom_range(31)), 16'($urandom), 16'($urandom),
                          $urandom_range(99) < 12, k);
        made += k;
      end else if (roll < 92) begin
        w = stray_command();
        if ($urandom_range(1))
          w.phy_address = 8'($urandom_range(255, 32));
        else
          w.register_address = 8'($urandom_range(255, 32));
        cmd_backlog.push_back(w);
        made++;
      end else begin
        repeat ($urandom_range(4, 1)) cmd_backlog.push_back(tick_word());
      end
    end
  endtask

  // Hold here until the sender has nothing left and every word is back;
  // look between edges so the driver's updates for the edge are settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || line_results_due.size() != 0);
  endtask

  task automatic set_preamble(input logic [5:0] value);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    preamble_setting = value;
  endtask

  // Driver: predict each word as it is taken, then offer the next one or
  // idle. Hold valid and the payload while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        line_results_due.push_back(mdio_frame_step(in_word));
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
          in_word <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction, then
  // stall at random for the next cycle.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (line_results_due.size() == 0) begin
          $error("result word arrived with no prediction pending");
          mismatch_count++;
        end else begin
          want = line_results_due.pop_front();
          check_field("drive_bit", want.drive_bit, seen_word.drive_bit);
          check_field("drive_enable", want.drive_enable, seen_word.drive_enable);
          check_field("clock_pulse", want.clock_pulse, seen_word.clock_pulse);
          check_field("busy_res", want.busy_res, seen_word.busy_res);
          check_field("done_res", want.done_res, seen_word.done_res);
          check_field("read_value", want.read_value, seen_word.read_value);
          check_field("status", want.status, seen_word.status);
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 34);
    end
  end

  // Watchdog: count cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    int words;
    int span_old;
    int k;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset length of 32 ones, no write yet; an idle tick and a bad address before it.
    cmd_backlog.push_back(tick_word());
    cmd_backlog.push_back(command_word(MODE_READ, 8'd32, 8'd0, 16'hFFFF, 16'hFFFF));
    queue_transaction(MODE_READ, 8'd31, 8'd0, 16'h0000, 16'h0000, 1'b1, words);
    wait_drained();

    // Shortest frames for the directed cases.
    set_preamble(6'd0);
    cmd_backlog.push_back(command_word(MODE_TICK, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    cmd_backlog.push_back(command_word(MODE_WRITE, 8'd0, 8'd255, 16'h0000, 16'h0000));
    cmd_backlog.push_back(command_word(MODE_MODIFY, 8'd255, 8'd32, 16'hFFFF, 16'hFFFF));
    queue_transaction(MODE_WRITE, 8'd31, 8'd31, 16'hFFFF, 16'h0000, 1'b1, words);
    queue_transaction(MODE_READ, 8'd0, 8'd0, 16'h0000, 16'hFFFF, 1'b0, words);
    queue_transaction(MODE_MODIFY, 8'd21, 8'd10, 16'hA5A5, 16'h0FF0, 1'b0, words);
    queue_transaction(MODE_WRITE, 8'd0, 8'd0, 16'h0000, 16'hFFFF, 1'b0, words);
    queue_transaction(MODE_MODIFY, 8'd31, 8'd0, 16'hFFFF, 16'hFFFF, 1'b1, words);
    queue_transaction(MODE_MODIFY, 8'd0, 8'd31, 16'hFFFF, 16'h0000, 1'b0, words);
    wait_drained();

    // All bits of the length set: clamps to the cap.
    set_preamble(6'd63);
    random_phase(PHASE_WORDS);
    wait_drained();

    // No gaps on either side for this phase.
    set_preamble(6'd0);
    steady = 1'b1;
    random_phase(PHASE_WORDS);
    wait_drained();
    steady = 1'b0;

    set_preamble(6'd1);
    random_phase(PHASE_WORDS);
    wait_drained();

    // Leave a modify stuck in its read frame, change the length, then
    // finish: the read frame keeps the old length, the write frame the new.
    span_old = frame_span(preamble_setting);
    k = $urandom_range(span_old - 1, 1);
    cmd_backlog.push_back(command_word(MODE_MODIFY, 8'($urandom_range(31)),
                                       8'($urandom_range(31)), 16'($urandom), 16'($urandom)));
    repeat (k) cmd_backlog.push_back(tick_word());
    wait_drained();
    set_preamble(6'd33);
    repeat (span_old - k + frame_span(preamble_setting)) cmd_backlog.push_back(tick_word());
    random_phase(PHASE_WORDS);
    wait_drained();

    set_preamble(6'd5);
    random_phase(PHASE_WORDS);
    wait_drained();

    set_preamble(6'd32);
    random_phase(PHASE_WORDS / 2);
    wait_drained();

    set_preamble(6'd2);
    random_phase(PHASE_WORDS);
    wait_drained();

    // Allow the two-stage pipe to settle before the verdict.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
rtl/mdio_c22_pkg.sv
rtl/mdio_c22_in_stage.sv
rtl/mdio_c22_core.sv
rtl/mdio_clause22_master.sv
bench/mdio_clause22_master_test.sv
